// ===== rtl/core/gear_shift_sequencer_defines.svh =====
// assertion macros used by the gear shift sequencer rtl
`ifndef GEAR_SHIFT_SEQUENCER_DEFINES_SVH
`define GEAR_SHIFT_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gss check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define GSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gss check failed: next-cycle implication");

`endif

// ===== rtl/core/gss_pkg.sv =====
// types, constants and codes for the gear shift sequencer
`default_nettype none
package gss_pkg;

   localparam int PREAMBLE_BYTES = 5;
   localparam int FRAME_BYTES    = 16;
   localparam int POS_W          = 5;
   localparam int TIMER_W        = 10;
   localparam int CMD_W          = 8;
   localparam int GEAR_W         = 8;
   localparam int CSR_IDX_W      = 3;
   localparam int RSP_DATA_W     = 16;

   localparam logic [CMD_W-1:0] CMD_UP      = 8'h75;  // 'u'
   localparam logic [CMD_W-1:0] CMD_DOWN    = 8'h64;  // 'd'
   localparam logic [CMD_W-1:0] CMD_NEUTRAL = 8'h6E;  // 'n'

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_U_ENG    = 4'd1,
      PH_U_PULSE  = 4'd2,
      PH_U_REL    = 4'd3,
      PH_U_WAIT   = 4'd4,
      PH_D_ENG    = 4'd5,
      PH_D_PULSE  = 4'd6,
      PH_D_REL    = 4'd7,
      PH_D_WAIT   = 4'd8,
      PH_N_PULSE  = 4'd9,
      PH_N_WAIT   = 4'd10,
      PH_N_SETTLE = 4'd11
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CLUTCH_ENGAGE  = 3'd0,
      REG_SHIFT_PULSE    = 3'd1,
      REG_CLUTCH_RELEASE = 3'd2,
      REG_NEUTRAL_PULSE  = 3'd3,
      REG_NEUTRAL_SETTLE = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [TIMER_W-1:0] clutch_engage;
      logic [TIMER_W-1:0] shift_pulse;
      logic [TIMER_W-1:0] clutch_release;
      logic [TIMER_W-1:0] neutral_pulse;
      logic [TIMER_W-1:0] neutral_settle;
   } timing_type;

   typedef struct packed {
      logic                     clutch_on;
      logic                     up_valve_on;
      logic                     down_valve_on;
      logic                     busy_res;
      logic signed [GEAR_W-1:0] gear_count;
   } drive_type;

endpackage
`default_nettype wire

// ===== rtl/core/gear_shift_sequencer.sv =====
// Gear shift sequencer top level.
// req channel: one beat per received serial byte or per 1 ms tick.
//   req_tuser selects the kind (0 = serial byte in req_tdata, 1 = tick).
// rsp channel: exactly one beat per req beat, carrying the clutch and
//   valve drives, the signed gear counter and a busy flag as they stand
//   after that req beat has been applied.
// csr channel: writes one of the five timing registers (ms ticks); it is
//   always ready and indexes beyond the list are dropped. Write it only
//   while no req beat is in flight.
// The rsp beat is registered: it appears in the cycle after its req beat is taken.
// Throughput: one beat per cycle unless the rsp side stalls; the frame parser, the phase update and
//   the output decode all settle in the cycle the req beat is taken, and
//   the rsp register frees req_tready in the same cycle it is read.
// Stall: while rsp_tvalid is high and rsp_tready low, req_tready is low
//   and the pending rsp beat holds.
// Reset: clears the frame position, command, phase, timer and gear count,
//   reloads the default timings and empties the rsp register.
`default_nettype none
`include "gear_shift_sequencer_defines.svh"
module gear_shift_sequencer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [7:0]                           req_tdata,  // [7:0] rx_byte
   input  wire logic                                 req_tuser,  // [0] mode
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] clutch_on, [1] up_valve_on, [2] down_valve_on, [10:3] gear_count,
   // [11] busy_res, [15:12] zero
   output logic [gss_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [gss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [gss_pkg::TIMER_W-1:0]          csr_data
);

   gss_pkg::timing_type          timing;
   gss_pkg::drive_type           drive_next;
   gss_pkg::drive_type           drive_ff;
   gss_pkg::drive_type           drive_in;
   logic [gss_pkg::CMD_W-1:0]    command_next;
   logic                         accept;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   gss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .timing    (timing)
   );

   gss_frame_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .is_tick      (req_tuser),
      .rx_byte      (req_tdata),
      .command_next (command_next)
   );

   gss_phase_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .is_tick    (req_tuser),
      .command    (command_next),
      .timing     (timing),
      .drive_next (drive_next)
   );

   always_comb begin
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
      drive_in     = accept ? drive_next : drive_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded on each taken req beat
   always_ff @(posedge clock) begin
      drive_ff <= drive_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, drive_ff.busy_res, drive_ff.gear_count,
                        drive_ff.down_valve_on, drive_ff.up_valve_on,
                        drive_ff.clutch_on};

   `GSS_ASSERT_IMPLY(a_idle_no_drive, clock, reset, rsp_valid_ff && !drive_ff.busy_res, !drive_ff.clutch_on && !drive_ff.up_valve_on && !drive_ff.down_valve_on)
   `GSS_ASSERT_IMPLY(a_valves_exclusive, clock, reset, rsp_valid_ff, !(drive_ff.up_valve_on && drive_ff.down_valve_on))
   `GSS_ASSERT_IMPLY(a_down_needs_clutch, clock, reset, rsp_valid_ff && drive_ff.down_valve_on, drive_ff.clutch_on)
   `GSS_ASSERT_NEXT(a_gear_step, clock, reset, accept && rsp_valid_ff, (drive_ff.gear_count == $past(drive_ff.gear_count)) || (drive_ff.gear_count == $past(drive_ff.gear_count) + 8'sd1) || (drive_ff.gear_count == $past(drive_ff.gear_count) - 8'sd1))

endmodule
`default_nettype wire

// ===== rtl/core/gss_csr.sv =====
// timing registers written over the csr channel
`default_nettype none
module gss_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [gss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gss_pkg::TIMER_W-1:0]      csr_data,
   output gss_pkg::timing_type                   timing
);

   gss_pkg::timing_type timing_ff;
   gss_pkg::timing_type timing_in;
   logic                write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   always_comb begin
      timing_in = timing_ff;
      if (write) begin
         unique case (csr_index)
            gss_pkg::REG_CLUTCH_ENGAGE:  timing_in.clutch_engage  = csr_data;
            gss_pkg::REG_SHIFT_PULSE:    timing_in.shift_pulse    = csr_data;
            gss_pkg::REG_CLUTCH_RELEASE: timing_in.clutch_release = csr_data;
            gss_pkg::REG_NEUTRAL_PULSE:  timing_in.neutral_pulse  = csr_data;
            gss_pkg::REG_NEUTRAL_SETTLE: timing_in.neutral_settle = csr_data;
            default:                     timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.clutch_engage  <= gss_pkg::TIMER_W'(70);
         timing_ff.shift_pulse    <= gss_pkg::TIMER_W'(1);
         timing_ff.clutch_release <= gss_pkg::TIMER_W'(20);
         timing_ff.neutral_pulse  <= gss_pkg::TIMER_W'(32);
         timing_ff.neutral_settle <= gss_pkg::TIMER_W'(30);
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign timing = timing_ff;

endmodule
`default_nettype wire

// ===== rtl/core/gss_frame_parser.sv =====
// frame parser: preamble check and command byte capture
`default_nettype none
module gss_frame_parser (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         is_tick,
   input  wire logic [gss_pkg::CMD_W-1:0]    rx_byte,
   output logic      [gss_pkg::CMD_W-1:0]    command_next
);

   logic [gss_pkg::POS_W-1:0] position_ff;
   logic [gss_pkg::POS_W-1:0] position_in;
   logic [gss_pkg::CMD_W-1:0] command_ff;
   logic [gss_pkg::CMD_W-1:0] command_in;
   logic [gss_pkg::POS_W-1:0] pos_start;

   always_comb begin
      // past the frame end the position restarts before the byte is taken
      pos_start   = (position_ff >= gss_pkg::POS_W'(gss_pkg::FRAME_BYTES)) ?
                    '0 : position_ff;
      position_in = position_ff;
      command_in  = command_ff;
      if (accept && !is_tick) begin
         if (pos_start < gss_pkg::POS_W'(gss_pkg::PREAMBLE_BYTES)) begin
            if (rx_byte == gss_pkg::CMD_W'(pos_start)) begin
               position_in = pos_start + gss_pkg::POS_W'(1);
            end else begin
               position_in = '0;
            end
         end else begin
            if (pos_start == gss_pkg::POS_W'(gss_pkg::PREAMBLE_BYTES)) begin
               command_in = rx_byte;
            end
            position_in = pos_start + gss_pkg::POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         command_ff  <= '0;
      end else begin
         position_ff <= position_in;
         command_ff  <= command_in;
      end
   end

   assign command_next = command_in;

endmodule
`default_nettype wire

// ===== rtl/core/gss_phase_seq.sv =====
// shift sequencer: timed phases, command waits and gear counter
`default_nettype none
module gss_phase_seq (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         is_tick,
   input  wire logic [gss_pkg::CMD_W-1:0]    command,
   input  gss_pkg::timing_type               timing,
   output gss_pkg::drive_type                drive_next
);

   gss_pkg::phase_type                phase_ff;
   gss_pkg::phase_type                phase_in;
   logic [gss_pkg::TIMER_W-1:0]       timer_ff;
   logic [gss_pkg::TIMER_W-1:0]       timer_in;
   logic [gss_pkg::GEAR_W-1:0]        gear_ff;
   logic [gss_pkg::GEAR_W-1:0]        gear_in;
   gss_pkg::phase_type                ph_tick;
   logic [gss_pkg::TIMER_W-1:0]       tmr_tick;
   gss_pkg::phase_type                ph_wait;
   logic [gss_pkg::TIMER_W-1:0]       tmr_wait;
   gss_pkg::phase_type                ph_new;
   logic [gss_pkg::TIMER_W-1:0]       tmr_new;
   logic [gss_pkg::GEAR_W-1:0]        gear_new;
   logic                              timed;

   always_comb begin
      unique case (phase_ff)
         gss_pkg::PH_U_ENG, gss_pkg::PH_U_PULSE, gss_pkg::PH_U_REL,
         gss_pkg::PH_D_ENG, gss_pkg::PH_D_PULSE, gss_pkg::PH_D_REL,
         gss_pkg::PH_N_PULSE, gss_pkg::PH_N_SETTLE: timed = 1'b1;
         default:                                   timed = 1'b0;
      endcase
   end

   // tick step: count down, a timer of zero or one ends the phase
   always_comb begin
      ph_tick  = phase_ff;
      tmr_tick = timer_ff;
      if (is_tick && timed) begin
         if (timer_ff > gss_pkg::TIMER_W'(1)) begin
            tmr_tick = timer_ff - gss_pkg::TIMER_W'(1);
         end else begin
            unique case (phase_ff)
               gss_pkg::PH_U_ENG: begin
                  ph_tick  = gss_pkg::PH_U_PULSE;
                  tmr_tick = timing.shift_pulse;
               end
               gss_pkg::PH_U_PULSE: begin
                  ph_tick  = gss_pkg::PH_U_REL;
                  tmr_tick = timing.clutch_release;
               end
               gss_pkg::PH_U_REL: begin
                  ph_tick  = gss_pkg::PH_U_WAIT;
                  tmr_tick = '0;
               end
               gss_pkg::PH_D_ENG: begin
                  ph_tick  = gss_pkg::PH_D_PULSE;
                  tmr_tick = timing.shift_pulse;
               end
               gss_pkg::PH_D_PULSE: begin
                  ph_tick  = gss_pkg::PH_D_REL;
                  tmr_tick = timing.clutch_release;
               end
               gss_pkg::PH_D_REL: begin
                  ph_tick  = gss_pkg::PH_D_WAIT;
                  tmr_tick = '0;
               end
               gss_pkg::PH_N_PULSE: begin
                  ph_tick  = gss_pkg::PH_N_WAIT;
                  tmr_tick = '0;
               end
               default: begin
                  ph_tick  = gss_pkg::PH_IDLE;
                  tmr_tick = '0;
               end
            endcase
         end
      end
   end

   // waits end when the command moves away; idle may start a new run at once
   always_comb begin
      ph_wait  = ph_tick;
      tmr_wait = tmr_tick;
      gear_new = gear_ff;
      priority if (ph_tick == gss_pkg::PH_U_WAIT && command != gss_pkg::CMD_UP) begin
         gear_new = gear_ff + gss_pkg::GEAR_W'(1);
         ph_wait  = gss_pkg::PH_IDLE;
         tmr_wait = '0;
      end else if (ph_tick == gss_pkg::PH_D_WAIT && command != gss_pkg::CMD_DOWN) begin
         gear_new = gear_ff - gss_pkg::GEAR_W'(1);
         ph_wait  = gss_pkg::PH_IDLE;
         tmr_wait = '0;
      end else if (ph_tick == gss_pkg::PH_N_WAIT &&
                   command != gss_pkg::CMD_NEUTRAL) begin
         ph_wait  = gss_pkg::PH_N_SETTLE;
         tmr_wait = timing.neutral_settle;
      end else begin
         ph_wait  = ph_tick;
      end

      ph_new  = ph_wait;
      tmr_new = tmr_wait;
      if (ph_wait == gss_pkg::PH_IDLE) begin
         priority if (command == gss_pkg::CMD_UP) begin
            ph_new  = gss_pkg::PH_U_ENG;
            tmr_new = timing.clutch_engage;
         end else if (command == gss_pkg::CMD_DOWN) begin
            ph_new  = gss_pkg::PH_D_ENG;
            tmr_new = timing.clutch_engage;
         end else if (command == gss_pkg::CMD_NEUTRAL) begin
            ph_new  = gss_pkg::PH_N_PULSE;
            tmr_new = timing.neutral_pulse;
         end else begin
            ph_new  = gss_pkg::PH_IDLE;
         end
      end
   end

   always_comb begin
      phase_in = accept ? ph_new   : phase_ff;
      timer_in = accept ? tmr_new  : timer_ff;
      gear_in  = accept ? gear_new : gear_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gss_pkg::PH_IDLE;
         timer_ff <= '0;
         gear_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         gear_ff  <= gear_in;
      end
   end

   always_comb begin
      unique case (ph_new)
         gss_pkg::PH_U_ENG, gss_pkg::PH_U_PULSE, gss_pkg::PH_U_REL,
         gss_pkg::PH_D_ENG, gss_pkg::PH_D_PULSE, gss_pkg::PH_D_REL:
                  drive_next.clutch_on = 1'b1;
         default: drive_next.clutch_on = 1'b0;
      endcase
      drive_next.up_valve_on   = (ph_new == gss_pkg::PH_U_PULSE) ||
                                 (ph_new == gss_pkg::PH_N_PULSE);
      drive_next.down_valve_on = (ph_new == gss_pkg::PH_D_PULSE);
      drive_next.busy_res      = (ph_new != gss_pkg::PH_IDLE);
      drive_next.gear_count    = gear_new;
   end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the gear shift sequencer: frame parsing, shift timing, gear count
`timescale 1ns / 1ps
module testbench;
   import gss_pkg::*;

   localparam logic        MODE_BYTE      = 1'b0;
   localparam logic        MODE_TICK      = 1'b1;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          RANDOM_PHASES  = 7;
   localparam int          RANDOM_ITEMS   = 1050;
   localparam int          LAST_CSR_INDEX = (1 << CSR_IDX_W) - 1;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [TIMER_W-1:0]     csr_data   = '0;

   // predicted state of the sequencer
   timing_type             shift_timing;
   logic [POS_W-1:0]       frame_pos;
   logic [CMD_W-1:0]       shift_cmd;
   phase_type              shift_phase;
   logic [TIMER_W-1:0]     phase_left;
   logic [GEAR_W-1:0]      gear_total;

   drive_type              expected_drives[$];
   int unsigned            mismatch_count  = 0;
   int unsigned            quiet_cycles    = 0;
   int unsigned            rsp_hold_cycles = 0;
   logic                   no_idle         = 1'b0;

   gear_shift_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void load_phase(input phase_type next, input logic [TIMER_W-1:0] ticks);
      shift_phase = next;
      phase_left  = ticks;
   endfunction

   // applies one req beat to the predicted state and returns the drives after it
   function automatic drive_type step_shifter(input logic is_tick, input logic [7:0] rx);
      drive_type d;
      if (!is_tick) begin
         if (frame_pos >= FRAME_BYTES)
            frame_pos = '0;
         if (frame_pos < PREAMBLE_BYTES) begin
            // a wrong preamble byte drops back to the start without a second look
            frame_pos = (rx == frame_pos) ? frame_pos + 1'b1 : '0;
         end else begin
            if (frame_pos == PREAMBLE_BYTES)
               shift_cmd = rx;
            frame_pos = frame_pos + 1'b1;
         end
      end else if (shift_phase inside {PH_U_ENG, PH_U_PULSE, PH_U_REL, PH_D_ENG, PH_D_PULSE,
                                       PH_D_REL, PH_N_PULSE, PH_N_SETTLE}) begin
         // a timer loaded with zero expires on the first tick, like one
         if (phase_left > 1)
            phase_left = phase_left - 1'b1;
         else begin
            case (shift_phase)
               PH_U_ENG:   load_phase(PH_U_PULSE, shift_timing.shift_pulse);
               PH_U_PULSE: load_phase(PH_U_REL, shift_timing.clutch_release);
               PH_U_REL:   load_phase(PH_U_WAIT, '0);
               PH_D_ENG:   load_phase(PH_D_PULSE, shift_timing.shift_pulse);
               PH_D_PULSE: load_phase(PH_D_REL, shift_timing.clutch_release);
               PH_D_REL:   load_phase(PH_D_WAIT, '0);
               PH_N_PULSE: load_phase(PH_N_WAIT, '0);
               default:    load_phase(PH_IDLE, '0);
            endcase
         end
      end

      if (shift_phase == PH_U_WAIT && shift_cmd != CMD_UP) begin
         gear_total = gear_total + 1'b1;
         load_phase(PH_IDLE, '0);
      end else if (shift_phase == PH_D_WAIT && shift_cmd != CMD_DOWN) begin
         gear_total = gear_total - 1'b1;
         load_phase(PH_IDLE, '0);
      end else if (shift_phase == PH_N_WAIT && shift_cmd != CMD_NEUTRAL) begin
         load_phase(PH_N_SETTLE, shift_timing.neutral_settle);
      end
      // a finished wait may start the next sequence on the same beat
      if (shift_phase == PH_IDLE) begin
         if (shift_cmd == CMD_UP)
            load_phase(PH_U_ENG, shift_timing.clutch_engage);
         else if (shift_cmd == CMD_DOWN)
            load_phase(PH_D_ENG, shift_timing.clutch_engage);
         else if (shift_cmd == CMD_NEUTRAL)
            load_phase(PH_N_PULSE, shift_timing.neutral_pulse);
      end

      d.clutch_on     = shift_phase inside {PH_U_ENG, PH_U_PULSE, PH_U_REL,
                                            PH_D_ENG, PH_D_PULSE, PH_D_REL};
      d.up_valve_on   = shift_phase inside {PH_U_PULSE, PH_N_PULSE};
      d.down_valve_on = shift_phase == PH_D_PULSE;
      d.busy_res      = shift_phase != PH_IDLE;
      d.gear_count    = gear_total;
      return d;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // scoreboard: rsp beats first, then csr writes, then new req beats
   always @(posedge clock) begin
      drive_type want;
      if (reset) begin
         shift_timing = '{clutch_engage: 70, shift_pulse: 1, clutch_release: 20,
                          neutral_pulse: 32, neutral_settle: 30};
         frame_pos   = '0;
         shift_cmd   = '0;
         shift_phase = PH_IDLE;
         phase_left  = '0;
         gear_total  = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_drives.size() == 0) begin
               $error("rsp beat %h with no result expected", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_drives.pop_front();
               check_field("clutch_on", want.clutch_on, rsp_tdata[0]);
               check_field("up_valve_on", want.up_valve_on, rsp_tdata[1]);
               check_field("down_valve_on", want.down_valve_on, rsp_tdata[2]);
               check_field("gear_count", int'(want.gear_count), int'($signed(rsp_tdata[10:3])));
               check_field("busy_res", want.busy_res, rsp_tdata[11]);
               check_field("pad", 0, rsp_tdata[15:12]);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CLUTCH_ENGAGE:  shift_timing.clutch_engage  = csr_data;
               REG_SHIFT_PULSE:    shift_timing.shift_pulse    = csr_data;
               REG_CLUTCH_RELEASE: shift_timing.clutch_release = csr_data;
               REG_NEUTRAL_PULSE:  shift_timing.neutral_pulse  = csr_data;
               REG_NEUTRAL_SETTLE: shift_timing.neutral_settle = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_drives.push_back(step_shifter(req_tuser, req_tdata));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // rsp sink: random stall bursts, plus a long hold-off on request
   initial begin : rsp_sink
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_item(input logic mode, input logic [7:0] value);
      if (!no_idle && $urandom_range(0, 15) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_item(MODE_TICK, $urandom_range(0, 255));
   endtask

   function automatic void append_frame(ref logic [7:0] q[$], input logic [7:0] cmd);
      for (int i = 0; i < PREAMBLE_BYTES; i++)
         q.push_back(i);
      q.push_back(cmd);
      // tach and wheel-speed bytes, never looked at
      repeat (FRAME_BYTES - PREAMBLE_BYTES - 1) q.push_back($urandom_range(0, 255));
   endfunction

   task automatic send_frame(input logic [7:0] cmd);
      logic [7:0] frame_bytes[$];
      append_frame(frame_bytes, cmd);
      while (frame_bytes.size() != 0)
         send_item(MODE_BYTE, frame_bytes.pop_front());
   endtask

   function automatic logic [7:0] random_other_cmd();
      logic [7:0] b;
      do b = $urandom_range(0, 255); while (b inside {CMD_UP, CMD_DOWN, CMD_NEUTRAL});
      return b;
   endfunction

   // sender pause: lower valid and wait for every outstanding rsp beat
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_drives.size() != 0) @(negedge clock);
   endtask

   task automatic write_timing(input logic [CSR_IDX_W-1:0] idx, input logic [TIMER_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // reset timings, preamble resync and a full neutral then up sequence
   task automatic test_reset_timings();
      send_item(MODE_BYTE, 0);
      send_item(MODE_BYTE, 1);
      send_item(MODE_BYTE, 0);   // wrong byte, not taken as a new start
      send_item(MODE_BYTE, 0);
      send_item(MODE_BYTE, 1);
      send_item(MODE_BYTE, 2);
      send_item(MODE_BYTE, 7);
      send_frame(CMD_NEUTRAL);
      send_ticks(34);
      send_frame(CMD_UP);
      send_ticks(125);
      send_frame(8'h00);
   endtask

   // every timer at zero, direction held while the command changes mid-shift
   task automatic test_zero_timers();
      wait_results_drained();
      write_timing(REG_CLUTCH_ENGAGE, '0);
      write_timing(REG_SHIFT_PULSE, '0);
      write_timing(REG_CLUTCH_RELEASE, '0);
      write_timing(REG_NEUTRAL_PULSE, '0);
      write_timing(REG_NEUTRAL_SETTLE, '0);
      send_frame(CMD_UP);
      send_ticks(1);
      send_frame(CMD_DOWN);
      send_ticks(2);
      send_ticks(3);
      send_frame(CMD_NEUTRAL);
      send_ticks(1);
      send_frame(8'hFF);
      send_ticks(1);
   endtask

   // walk the gear count down through zero and past the signed minimum
   task automatic test_gear_wrap();
      repeat (130) begin
         send_frame(CMD_DOWN);
         send_ticks(3);
         send_frame(random_other_cmd());
      end
   endtask

   // new timings land only when a phase is next entered; stray indexes do nothing
   task automatic test_mid_phase_write();
      wait_results_drained();
      write_timing(REG_CLUTCH_ENGAGE, 6);
      write_timing(REG_CLUTCH_RELEASE, 1);
      send_frame(CMD_UP);
      send_ticks(2);
      wait_results_drained();
      write_timing(REG_CLUTCH_ENGAGE, '0);
      write_timing(REG_SHIFT_PULSE, 2);
      for (int i = REG_NEUTRAL_SETTLE + 1; i <= LAST_CSR_INDEX; i++)
         write_timing(i, $urandom_range(0, (1 << TIMER_W) - 1));
      send_ticks(8);
      send_frame(CMD_NEUTRAL);
      send_ticks(1);
      send_frame(random_other_cmd());
      send_ticks(1);
   endtask

   // hold the rsp side long enough for req_tready to drop, then drain
   task automatic test_rsp_backpressure();
      @(posedge clock);
      rsp_hold_cycles = 60;
      @(negedge clock);
      send_frame(CMD_UP);
      send_ticks(6);
      send_frame(random_other_cmd());
      wait_results_drained();
   endtask

   // largest timer value counted out in full
   task automatic test_long_timer();
      wait_results_drained();
      write_timing(REG_CLUTCH_ENGAGE, '1);
      write_timing(REG_SHIFT_PULSE, '1);
      write_timing(REG_CLUTCH_RELEASE, '1);
      write_timing(REG_NEUTRAL_PULSE, '1);
      write_timing(REG_NEUTRAL_SETTLE, '0);
      send_frame(CMD_NEUTRAL);
      send_ticks(1023);
      send_frame(random_other_cmd());
      send_ticks(1);
   endtask

   // mostly well-formed frames with ticks woven in, some broken preambles and stray bytes
   task automatic test_random_traffic();
      logic [7:0]  pending[$];
      logic [7:0]  cmd;
      int unsigned sent;
      int unsigned cut;
      for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
         wait_results_drained();
         for (int r = REG_CLUTCH_ENGAGE; r <= REG_NEUTRAL_SETTLE; r++)
            write_timing(r, (phase_no % 3 == 2) ? $urandom_range(0, 15) : $urandom_range(0, 3));
         if ($urandom_range(0, 1))
            write_timing($urandom_range(REG_NEUTRAL_SETTLE + 1, LAST_CSR_INDEX),
                         $urandom_range(0, (1 << TIMER_W) - 1));
         if (phase_no == RANDOM_PHASES - 1) begin
            @(posedge clock);
            no_idle = 1'b1;
            @(negedge clock);
         end
         sent = 0;
         while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
            if (pending.size() == 0) begin
               case ($urandom_range(0, 9))
                  0: begin
                     cut = $urandom_range(0, PREAMBLE_BYTES - 1);
                     for (int i = 0; i < cut; i++)
                        pending.push_back(i);
                     pending.push_back(cut + $urandom_range(1, 255));
                  end
                  1: pending.push_back($urandom_range(0, 255));
                  default: begin
                     case ($urandom_range(0, 9))
                        0, 1, 2: cmd = CMD_UP;
                        3, 4, 5: cmd = CMD_DOWN;
                        6, 7:    cmd = CMD_NEUTRAL;
                        default: cmd = random_other_cmd();
                     endcase
                     append_frame(pending, cmd);
                  end
               endcase
            end
            if ($urandom_range(0, 9) < 6)
               send_item(MODE_BYTE, pending.pop_front());
            else
               send_item(MODE_TICK, $urandom_range(0, 255));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_timings();
      test_zero_timers();
      test_gear_wrap();
      test_mid_phase_write();
      test_rsp_backpressure();
      test_long_timer();
      test_random_traffic();
      wait_results_drained();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && expected_drives.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
